### hdl/ipv4_cidr_text_parser_macros.svh
// Assertion macros for the IPv4 CIDR text parser.
`ifndef IPV4_CIDR_TEXT_PARSER_MACROS_SVH
`define IPV4_CIDR_TEXT_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, off while reset is low
`define CIDRP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property with no reset qualifier
`define CIDRP_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CIDRP_ASSERT(lbl, clk, rst_n, prop, msg)
`define CIDRP_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

### hdl/cidrp_pkg.sv
// Shared constants and types for the IPv4 CIDR text parser.
package cidrp_pkg;

    // Character codes
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Field limits
    localparam logic [9:0] OCTET_MAX  = 10'd255;
    localparam logic [9:0] PREFIX_MAX = 10'd32;

    // Field index codes
    localparam logic [2:0] FIELD_LAST_OCTET = 3'd3;
    localparam logic [2:0] FIELD_PREFIX     = 3'd4;

    localparam logic [1:0] DIGITS_MAX = 2'd3;

    // Result word from the parser core
    typedef struct packed {
        logic        ok;
        logic [31:0] address;
        logic [5:0]  prefix_len;
    } t_result;

endpackage

### hdl/ipv4_cidr_text_parser.sv
// IPv4 CIDR text parser: input register, parser core and result register.
// A result is shown from the result register once the word marked last has passed the input register.
// Throughput: one character word per cycle while o_stall is low; the parser core updates as each word is taken.
// Input register and result register advance together whenever the result is free.
// Reset (i_rst_n low, synchronous) empties both registers and clears the parser state.
`include "ipv4_cidr_text_parser_macros.svh"

module ipv4_cidr_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic [31:0] o_address,
    output logic [5:0]  o_prefix_len
);

    logic               r_in_valid;
    logic [7:0]         r_ch;
    logic               r_last;
    logic               r_out_valid;
    cidrp_pkg::t_result r_res;
    cidrp_pkg::t_result core_res;
    logic               advance;

    // Pipeline moves when the result register is empty or being taken
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
    end

    cidrp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (advance && r_in_valid),
        .i_ch    (r_ch),
        .i_last  (r_last),
        .o_res   (core_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= core_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ok         = r_res.ok;
    assign o_address    = r_res.address;
    assign o_prefix_len = r_res.prefix_len;

    `CIDRP_ASSERT(a_stall_cause, i_clk, i_rst_n,
        o_stall |-> (r_in_valid && r_out_valid),
        "input stalled without a held result")
    `CIDRP_ASSERT(a_last_gives_result, i_clk, i_rst_n,
        (r_in_valid && r_last && !o_stall) |=> o_valid,
        "last word gave no result")
    `CIDRP_ASSERT(a_no_spurious_result, i_clk, i_rst_n,
        (advance && !(r_in_valid && r_last)) |=> !o_valid,
        "result without a last word")

endmodule

### hdl/cidrp_core.sv
// Parser state and per-character next-state logic for the CIDR text parser.
`include "ipv4_cidr_text_parser_macros.svh"

module cidrp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_ch,
    input  logic                i_last,
    output cidrp_pkg::t_result  o_res
);

    logic [2:0]  r_field_index, n_field_index;
    logic [1:0]  r_digit_count, n_digit_count;
    logic [9:0]  r_accumulator, n_accumulator;
    logic [23:0] r_octets, n_octets;
    logic [7:0]  r_fourth, n_fourth;
    logic        r_error, n_error;
    logic        r_term, n_term;

    logic        is_digit;
    logic [3:0]  digit_val;
    logic [13:0] acc_x10;
    logic        field_ok_octet;
    logic        valid;

    // Digit decode and accumulate
    assign is_digit       = (i_ch >= cidrp_pkg::CH_ZERO) && (i_ch <= cidrp_pkg::CH_NINE);
    assign digit_val      = 4'(i_ch - cidrp_pkg::CH_ZERO);
    assign acc_x10        = 14'(r_accumulator) * 14'd10;
    assign field_ok_octet = (r_digit_count != 2'd0) && (r_accumulator <= cidrp_pkg::OCTET_MAX);

    // Next state for one character
    always_comb begin
        n_field_index = r_field_index;
        n_digit_count = r_digit_count;
        n_accumulator = r_accumulator;
        n_octets      = r_octets;
        n_fourth      = r_fourth;
        n_error       = r_error;
        n_term        = r_term;
        if (r_term || r_error) begin
            // string already ended or failed: ignore
        end else if (i_ch == cidrp_pkg::CH_NUL) begin
            n_term = 1'b1;
        end else if (is_digit) begin
            if (r_digit_count == cidrp_pkg::DIGITS_MAX) begin
                n_error = 1'b1;
            end else begin
                n_accumulator = 10'(acc_x10 + 14'(digit_val));
                n_digit_count = r_digit_count + 2'd1;
            end
        end else if (i_ch == cidrp_pkg::CH_DOT && r_field_index < cidrp_pkg::FIELD_LAST_OCTET
                     && field_ok_octet) begin
            n_octets      = {r_octets[15:0], r_accumulator[7:0]};
            n_field_index = r_field_index + 3'd1;
            n_digit_count = 2'd0;
            n_accumulator = 10'd0;
        end else if (i_ch == cidrp_pkg::CH_SLASH && r_field_index == cidrp_pkg::FIELD_LAST_OCTET
                     && field_ok_octet) begin
            n_fourth      = r_accumulator[7:0];
            n_field_index = cidrp_pkg::FIELD_PREFIX;
            n_digit_count = 2'd0;
            n_accumulator = 10'd0;
        end else begin
            n_error = 1'b1;
        end
    end

    // Result as seen after this character
    assign valid = !n_error && (n_field_index == cidrp_pkg::FIELD_PREFIX)
                   && (n_digit_count != 2'd0) && (n_accumulator <= cidrp_pkg::PREFIX_MAX);

    always_comb begin
        o_res.ok         = valid;
        o_res.address    = valid ? {n_octets, n_fourth} : 32'd0;
        o_res.prefix_len = valid ? n_accumulator[5:0] : 6'd0;
    end

    // State registers; a last character returns everything to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_field_index <= 3'd0;
            r_digit_count <= 2'd0;
            r_accumulator <= 10'd0;
            r_octets      <= 24'd0;
            r_fourth      <= 8'd0;
            r_error       <= 1'b0;
            r_term        <= 1'b0;
        end else if (i_take) begin
            r_field_index <= n_field_index;
            r_digit_count <= n_digit_count;
            r_accumulator <= n_accumulator;
            r_octets      <= n_octets;
            r_fourth      <= n_fourth;
            r_error       <= n_error;
            r_term        <= n_term;
        end
    end

    `CIDRP_ASSERT(a_clear_after_last, i_clk, i_rst_n, (i_take && i_last) |=> (r_field_index == 3'd0 && r_digit_count == 2'd0 && !r_error && !r_term), "parser state not cleared after last word")
    `CIDRP_ASSERT(a_field_range, i_clk, i_rst_n, r_field_index <= cidrp_pkg::FIELD_PREFIX, "field index beyond prefix field")
    `CIDRP_ASSERT(a_ok_prefix, i_clk, i_rst_n, o_res.ok |-> (o_res.prefix_len <= 6'd32), "ok result with prefix above 32")
    `CIDRP_ASSERT(a_hold_idle, i_clk, i_rst_n, !i_take |=> ($stable(r_accumulator) && $stable(r_field_index) && $stable(r_error)), "parser state moved without a word")

endmodule

### dv/tb.sv
// Self-checking testbench for the IPv4 CIDR text parser: stimulus, prediction, checking.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Predicts the parse of each string and checks results in arrival order
    class cidr_scoreboard;
        logic [2:0]         field_idx;
        logic [1:0]         n_digits;
        logic [9:0]         acc;
        logic [23:0]        upper_octets;
        logic [7:0]         low_octet;
        bit                 broken;
        bit                 ended;
        cidrp_pkg::t_result parse_q[$];
        int                 mismatches;
        int                 n_ok;
        int                 n_rejected;

        function new();
            mismatches = 0;
            n_ok       = 0;
            n_rejected = 0;
            clear();
        endfunction

        function void clear();
            field_idx    = '0;
            n_digits     = '0;
            acc          = '0;
            upper_octets = '0;
            low_octet    = '0;
            broken       = 1'b0;
            ended        = 1'b0;
        endfunction

        function int pending();
            return parse_q.size();
        endfunction

        task flag(string msg);
            mismatches++;
            $display("tb: mismatch: %s", msg);
        endtask

        // Advance the parse by one accepted word; a word marked last closes the string
        function void note_word(logic [7:0] c, logic l);
            cidrp_pkg::t_result res;
            if (!ended && !broken) begin
                if (c == cidrp_pkg::CH_NUL) begin
                    ended = 1'b1;
                end else if (c >= cidrp_pkg::CH_ZERO && c <= cidrp_pkg::CH_NINE) begin
                    if (n_digits == cidrp_pkg::DIGITS_MAX) begin
                        broken = 1'b1;
                    end else begin
                        acc      = 10'(acc * 10 + (c - cidrp_pkg::CH_ZERO));
                        n_digits = n_digits + 2'd1;
                    end
                end else if (c == cidrp_pkg::CH_DOT && field_idx < cidrp_pkg::FIELD_LAST_OCTET
                             && n_digits != 0 && acc <= cidrp_pkg::OCTET_MAX) begin
                    upper_octets = {upper_octets[15:0], acc[7:0]};
                    field_idx    = field_idx + 3'd1;
                    n_digits     = '0;
                    acc          = '0;
                end else if (c == cidrp_pkg::CH_SLASH
                             && field_idx == cidrp_pkg::FIELD_LAST_OCTET
                             && n_digits != 0 && acc <= cidrp_pkg::OCTET_MAX) begin
                    low_octet = acc[7:0];
                    field_idx = cidrp_pkg::FIELD_PREFIX;
                    n_digits  = '0;
                    acc       = '0;
                end else begin
                    broken = 1'b1;
                end
            end
            if (l) begin
                if (!broken && field_idx == cidrp_pkg::FIELD_PREFIX && n_digits != 0
                    && acc <= cidrp_pkg::PREFIX_MAX) begin
                    res.ok         = 1'b1;
                    res.address    = {upper_octets, low_octet};
                    res.prefix_len = acc[5:0];
                    n_ok++;
                end else begin
                    res = '0;
                    n_rejected++;
                end
                parse_q.push_back(res);
                clear();
            end
        endfunction

        task check_result(cidrp_pkg::t_result got);
            cidrp_pkg::t_result want;
            if (parse_q.size() == 0) begin
                flag($sformatf("result with none pending: ok %0b addr %08h prefix %0d",
                               got.ok, got.address, got.prefix_len));
                return;
            end
            want = parse_q.pop_front();
            if (got.ok !== want.ok)
                flag($sformatf("ok got %0b want %0b", got.ok, want.ok));
            if (got.address !== want.address)
                flag($sformatf("address got %08h want %08h", got.address, want.address));
            if (got.prefix_len !== want.prefix_len)
                flag($sformatf("prefix_len got %0d want %0d",
                               got.prefix_len, want.prefix_len));
        endtask
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [7:0]  i_ch         = '0;
    logic        i_last       = 1'b0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_ok;
    logic [31:0] o_address;
    logic [5:0]  o_prefix_len;

    cidr_scoreboard sb = new();

    logic [7:0] text_q[$];
    int         sep_pos[$];
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         rx_hold     = 0;
    int         n_words     = 0;
    int         n_strings   = 0;

    ipv4_cidr_text_parser u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ch         (i_ch),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ok         (o_ok),
        .o_address    (o_address),
        .o_prefix_len (o_prefix_len)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: random stall, or a long hold-off when one is requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                i_stall <= 1'b1;
                rx_hold = rx_hold - 1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{o_ok, o_address, o_prefix_len});
    end

    // Offer one word, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_word(logic [7:0] c, logic l);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        i_last  <= l;
        do @(posedge i_clk); while (o_stall);
        sb.note_word(c, l);
    endtask

    // Send the string held in text_q; words after a terminator are not counted
    task automatic send_text();
        bit seen_nul;
        seen_nul = 1'b0;
        foreach (text_q[i]) begin
            send_word(text_q[i], i == text_q.size() - 1);
            if (!seen_nul)
                n_words++;
            if (text_q[i] == cidrp_pkg::CH_NUL)
                seen_nul = 1'b1;
        end
        n_strings++;
    endtask

    task automatic load_text(string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // Decimal digits of v, zero-padded to width (width 0 gives an empty field)
    task automatic add_field(int v, int width);
        int div;
        for (int k = width - 1; k >= 0; k--) begin
            div = 1;
            repeat (k) div *= 10;
            text_q.push_back(8'(cidrp_pkg::CH_ZERO + (v / div) % 10));
        end
    endtask

    // Mostly well-formed CIDR strings; the rest carry one kind of damage
    task automatic make_random_text();
        int vals[5];
        int widths[5];
        int dmg;
        int pick;
        int k;
        int n;
        text_q.delete();
        sep_pos.delete();
        dmg = ($urandom_range(99) < 60) ? -1 : $urandom_range(9);
        for (k = 0; k < 5; k++) begin
            pick = $urandom_range(5);
            if (k < 4)
                vals[k] = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(255);
            else
                vals[k] = (pick == 0) ? 0 : (pick == 1) ? 32 : $urandom_range(32);
        end
        // octet above 255, prefix above 32
        if (dmg == 0)
            vals[$urandom_range(3)] = $urandom_range(999, 256);
        if (dmg == 1)
            vals[4] = $urandom_range(999, 33);
        for (k = 0; k < 5; k++) begin
            n = (vals[k] >= 100) ? 3 : (vals[k] >= 10) ? 2 : 1;
            widths[k] = $urandom_range(3, n);
        end
        // fourth digit, empty field
        if (dmg == 2)
            widths[$urandom_range(4)] = 4;
        if (dmg == 3)
            widths[$urandom_range(4)] = 0;
        for (k = 0; k < 5; k++) begin
            add_field(vals[k], widths[k]);
            if (k < 4) begin
                sep_pos.push_back(text_q.size());
                text_q.push_back((k < 3) ? cidrp_pkg::CH_DOT : cidrp_pkg::CH_SLASH);
            end
        end
        case (dmg)
            // wrong separator
            4: text_q[sep_pos[$urandom_range(3)]] = 8'($urandom_range(255));
            // trailing characters
            5: repeat ($urandom_range(3, 1))
                   text_q.push_back($urandom_range(1)
                                    ? 8'(cidrp_pkg::CH_ZERO + $urandom_range(9))
                                    : 8'($urandom_range(255)));
            // terminator somewhere, junk after it
            6: begin
                k = $urandom_range(text_q.size());
                if (k == text_q.size())
                    text_q.push_back(cidrp_pkg::CH_NUL);
                else
                    text_q.insert(k, cidrp_pkg::CH_NUL);
                repeat ($urandom_range(3)) text_q.push_back(8'($urandom_range(255)));
            end
            // cut short
            7: begin
                n = $urandom_range(text_q.size() - 1, 1);
                while (text_q.size() > n) void'(text_q.pop_back());
            end
            // extra separator
            8: text_q.insert($urandom_range(text_q.size() - 1),
                             $urandom_range(1) ? cidrp_pkg::CH_DOT : cidrp_pkg::CH_SLASH);
            // pure noise
            9: begin
                text_q.delete();
                repeat ($urandom_range(20, 1)) text_q.push_back(8'($urandom_range(255)));
            end
            default: ;
        endcase
    endtask

    // Sender stops offering until every pending result is out
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic run_phase(int tx_pct, int rx_pct, int word_goal);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (n_words < word_goal) begin
            make_random_text();
            send_text();
        end
        wait_drained();
    endtask

    // Main sequence
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: widest and smallest valid strings, bare terminator with ignored tail
        load_text("255.255.255.255/32");
        send_text();
        load_text("0.0.0.0/0");
        send_text();
        text_q = '{cidrp_pkg::CH_NUL, 8'hFF};
        send_text();
        wait_drained();

        run_phase(35, 87, 300);
        // pause mid-run until the parser is empty
        wait_drained();
        run_phase(35, 87, 540);
        run_phase(87, 35, 1050);

        // receiver holds off while words keep coming, so the input backs up
        rx_hold = 80;
        run_phase(0, 0, 1560);

        repeat (10) @(posedge i_clk);
        $display("tb: %0d strings, %0d characters parsed; %0d valid, %0d rejected",
                 n_strings, n_words, sb.n_ok, sb.n_rejected);
        if (sb.mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: %0d mismatches", sb.mismatches);
            $display("tb: done, errors");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("tb: timeout");
        $display("tb: done, errors");
        $finish;
    end

endmodule
